// ===== rtl/core/bf5r_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bf5r_pkg
// Shared types, widths and constants of the five-tap reflect-padded box filter.
// ----------------------------------------------------------------------------
package bf5r_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int OUT_BITS    = 24;
    localparam int TAPS        = 5;

    // sum of five samples
    localparam int SUM_BITS    = SAMPLE_BITS + 3;
    // biased, scaled sum: always positive and below 2^U_BITS
    localparam int U_BITS      = SAMPLE_BITS + FRAC_BITS + 3;
    localparam int BIAS_EXP    = SAMPLE_BITS - 1 + FRAC_BITS;
    localparam int DIV_SHIFT   = U_BITS + 3;
    localparam int RECIP_BITS  = U_BITS + 1;
    localparam int PROD_BITS   = U_BITS + RECIP_BITS;
    localparam int QUOT_BITS   = PROD_BITS - DIV_SHIFT;

    localparam logic [RECIP_BITS-1:0] RECIP_FIVE =
        RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'(TAPS - 1)) / 64'(TAPS));
    // TAPS * 2^BIAS_EXP moves every value positive, plus half a step for rounding
    localparam logic [U_BITS-1:0] ROUND_OFFSET =
        U_BITS'((64'(TAPS) << BIAS_EXP) + 64'(TAPS / 2));
    localparam logic [QUOT_BITS-1:0] QUOT_BIAS = QUOT_BITS'(64'd1 << BIAS_EXP);

    // result queue
    localparam int QDEPTH   = 4;
    localparam int CNT_BITS = 3;
    localparam int MAX_PUSH = 3;

    // position in frame
    localparam logic [1:0] POS_START  = 2'd0;
    localparam logic [1:0] POS_FILL   = 2'd2;
    localparam logic [1:0] POS_STEADY = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          frame_end;
    } t_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] smoothed;
        logic                       end_of_frame;
        logic                       short_frame;
    } t_out;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic                       eof;
        logic                       err;
    } t_res;

    typedef struct packed {
        logic [1:0]          cnt;
        t_res [MAX_PUSH-1:0] res;
    } t_push;

    function automatic logic signed [SUM_BITS-1:0] sx(
        input logic signed [SAMPLE_BITS-1:0] v
    );
        return SUM_BITS'(v);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bf5r_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bf5r_window
// Padded sample window and frame position; forms up to three tap sums per
// accepted sample.
// ----------------------------------------------------------------------------
module bf5r_window (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_acc,
    input  wire bf5r_pkg::t_in  i_in,
    output bf5r_pkg::t_push     o_push
);
    import bf5r_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_win [4];
    logic signed [SAMPLE_BITS-1:0] n_win [4];
    logic [1:0]                    r_pos;
    logic [1:0]                    n_pos;
    logic signed [SAMPLE_BITS-1:0] x;

    assign x = i_in.sample;

    always_comb begin
        n_win  = r_win;
        n_pos  = r_pos;
        o_push = '0;
        if (i_acc) begin
            if (r_pos < POS_FILL) begin
                if (i_in.frame_end) begin
                    // short frame
                    o_push.cnt        = 2'd1;
                    o_push.res[0].eof = 1'b1;
                    o_push.res[0].err = 1'b1;
                    n_pos             = POS_START;
                end else begin
                    n_win[r_pos] = x;
                    n_pos        = r_pos + 2'd1;
                end
            end else begin
                if (r_pos == POS_FILL) begin
                    // mirrored start: x2 x1 x0 x1 x2
                    o_push.res[0].sum = sx(x) + sx(x) + sx(r_win[1]) + sx(r_win[1])
                                      + sx(r_win[0]);
                    n_win[0] = r_win[1];
                    n_win[1] = r_win[0];
                    n_win[2] = r_win[1];
                    n_win[3] = x;
                end else begin
                    o_push.res[0].sum = sx(r_win[0]) + sx(r_win[1]) + sx(r_win[2])
                                      + sx(r_win[3]) + sx(x);
                    n_win[0] = r_win[1];
                    n_win[1] = r_win[2];
                    n_win[2] = r_win[3];
                    n_win[3] = x;
                end
                o_push.cnt = 2'd1;
                n_pos      = POS_STEADY;
                if (i_in.frame_end) begin
                    // mirrored tail
                    o_push.res[1].sum = sx(n_win[0]) + sx(n_win[1]) + sx(n_win[2])
                                      + sx(n_win[2]) + sx(n_win[3]);
                    o_push.res[2].sum = sx(n_win[1]) + sx(n_win[1]) + sx(n_win[2])
                                      + sx(n_win[2]) + sx(n_win[3]);
                    o_push.res[2].eof = 1'b1;
                    o_push.cnt        = 2'd3;
                    n_pos             = POS_START;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_START;
            for (int i = 0; i < 4; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_pos <= n_pos;
            r_win <= n_win;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/bf5r_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bf5r_scale
// Turns a five-tap sum into the rounded fixed-point average by a reciprocal
// multiply on the biased scaled sum.
// ----------------------------------------------------------------------------
module bf5r_scale (
    input  wire bf5r_pkg::t_res i_res,
    output bf5r_pkg::t_out      o_out
);
    import bf5r_pkg::*;

    logic [U_BITS-1:0]           num_ext;
    logic [U_BITS-1:0]           biased;
    logic [PROD_BITS-1:0]        prod;
    logic [QUOT_BITS-1:0]        quot;
    logic signed [QUOT_BITS-1:0] avg;

    assign num_ext = U_BITS'(i_res.sum);
    // floor((num + 2) / 5) is round to nearest, ties never occur
    assign biased  = (num_ext << FRAC_BITS) + ROUND_OFFSET;
    assign prod    = PROD_BITS'(biased) * PROD_BITS'(RECIP_FIVE);
    assign quot    = prod[PROD_BITS-1:DIV_SHIFT];
    assign avg     = signed'(quot - QUOT_BIAS);

    assign o_out.smoothed     = OUT_BITS'(avg);
    assign o_out.end_of_frame = i_res.eof;
    assign o_out.short_frame  = i_res.err;

endmodule
`default_nettype wire

// ===== rtl/core/bf5r_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bf5r_outq
// Result queue of tap sums, drained one per cycle through the scaler into
// the output register whenever that register is empty or not stalled.
// ----------------------------------------------------------------------------
module bf5r_outq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bf5r_pkg::t_push i_push,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output bf5r_pkg::t_out       o_data
);
    import bf5r_pkg::*;

    t_res                r_q [QDEPTH];
    t_res                n_q [QDEPTH];
    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_BITS-1:0] n_cnt;
    logic [CNT_BITS-1:0] base;
    logic                load_out;
    logic                r_valid;
    t_out                r_data;
    t_out                scaled;

    bf5r_scale u_scale (
        .i_res (r_q[0]),
        .o_out (scaled)
    );

    assign load_out = (r_cnt != '0) && (!r_valid || !i_stall);
    assign base     = r_cnt - CNT_BITS'(load_out);
    assign n_cnt    = base + CNT_BITS'(i_push.cnt);
    // room for a full frame tail after at most one queued result
    assign o_full   = r_cnt > CNT_BITS'(1);

    always_comb begin
        n_q = r_q;
        if (load_out) begin
            for (int i = 0; i < QDEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        for (int i = 0; i < QDEPTH; i++) begin
            for (int j = 0; j < MAX_PUSH; j++) begin
                if ((2'(j) < i_push.cnt) && ((base + CNT_BITS'(j)) == CNT_BITS'(i))) begin
                    n_q[i] = i_push.res[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (load_out) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (load_out) begin
            r_data <= scaled;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== rtl/core/box_filter_five_tap_reflect.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_five_tap_reflect
// Five-tap box average over frames of signed samples, mirror padded at both
// ends, rounded to 8 fractional bits.
// ----------------------------------------------------------------------------
//  channel   direction   handshake                   payload
//  sample    in          i_in_valid / o_in_stall     i_in_data  (t_in)
//  result    out         o_out_valid / i_out_stall   o_out_data (t_out)
//
//  one sample accepted per cycle while o_in_stall is low; results are registered
//  a full frame end queues three results (a short frame end queues one), so the
//  input stalls while the tail drains through the single output register
//  synchronous active-low reset empties the queue and restarts the frame
//  output stalls back up through the four-entry result queue
// ----------------------------------------------------------------------------
module box_filter_five_tap_reflect (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire bf5r_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output bf5r_pkg::t_out      o_out_data
);
    import bf5r_pkg::*;

    logic  in_acc;
    t_push push;

    assign in_acc = i_in_valid && !o_in_stall;

    bf5r_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_in    (i_in_data),
        .o_push  (push)
    );

    bf5r_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_push_only_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt != 2'd0) |-> in_acc)
        else $error("results queued without an input transfer");

    a_frame_end_queues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.frame_end) |-> (push.cnt == 2'd1 || push.cnt == 2'd3))
        else $error("frame end queued a wrong number of results");

    a_short_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.short_frame) |->
            (o_out_data.end_of_frame && o_out_data.smoothed == '0))
        else $error("short frame result malformed");

    a_no_output_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");
`endif

endmodule
`default_nettype wire
